>>> rtl/ctk_pkg.sv
// Shared constants, types and helper functions of the card line tokenizer.
package ctk_pkg;

   // Line and token limits.
   localparam int MAX_TOKENS  = 16;
   localparam int LINE_WIDTH  = 80;
   localparam int TOKEN_CNT_W = $clog2(MAX_TOKENS + 1);
   localparam int LINE_POS_W  = $clog2(LINE_WIDTH + 1);

   // Delimiter register layout.
   localparam int DELIM_SLOTS   = 8;
   localparam int DELIM_BYTES_W = 8 * DELIM_SLOTS;
   localparam int DELIM_COUNT_W = 4;

   // Characters with a fixed meaning.
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;

   // Configuration register indexes.
   localparam logic CSR_DELIM_BYTES = 1'b0;
   localparam logic CSR_DELIM_COUNT = 1'b1;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_LINE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  token_number;
      logic [6:0]  char_offset;
      logic [7:0]  char_out;
      logic [4:0]  token_total;
   } result_type;

   // Low four bits of a token counter value.
   function automatic logic [3:0] tok_of(input logic [TOKEN_CNT_W-1:0] v);
      logic [TOKEN_CNT_W+3:0] w;
      w = {4'b0, v};
      return w[3:0];
   endfunction

   // Low five bits of a token counter value.
   function automatic logic [4:0] total_of(input logic [TOKEN_CNT_W-1:0] v);
      logic [TOKEN_CNT_W+4:0] w;
      w = {5'b0, v};
      return w[4:0];
   endfunction

endpackage

>>> rtl/card_line_tokenizer.sv
// Top level of the card line tokenizer: scan state, result buffer and output drain.
//
//   channel | direction | handshake                | payload
//   req     | in        | req_valid / req_stall    | req_char_in, req_line_last
//   rsp     | out       | rsp_valid / rsp_stall    | kind, token, offset, char, total, last
//   csr     | in        | csr_write_enable         | csr_index, csr_write_data
//
// Each accepted word is scanned in the cycle it is accepted and yields zero to three
// results, loaded into a three-entry result buffer that drains one result per cycle
// while rsp is not stalled. A new word is taken in the same cycle the last buffered
// result leaves. Reset (synchronous, active high) clears the scan state and the buffer
// and loads the default delimiter set. A stall on rsp holds the buffer; req stalls
// while anything but a leaving last result is pending.
module card_line_tokenizer
   import ctk_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Input words.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_char_in,
   input  logic                     req_line_last,
   // Result words.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_result_kind,
   output logic [3:0]               rsp_token_number,
   output logic [6:0]               rsp_char_offset,
   output logic [7:0]               rsp_char_out,
   output logic [4:0]               rsp_token_total,
   output logic                     rsp_result_last,
   // Configuration writes.
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [DELIM_BYTES_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      MODE_BETWEEN,
      MODE_WORD,
      MODE_QUOTE,
      MODE_COMMENT
   } mode_type;

   // Configuration registers.
   logic [DELIM_BYTES_W-1:0] delim_bytes_ff;
   logic [DELIM_COUNT_W-1:0] delim_count_ff;

   // Scan state and its next values.
   mode_type                 mode_ff, mode_in;
   logic                     quote_dq_ff, quote_dq_in;
   logic [TOKEN_CNT_W-1:0]   tok_cnt_ff, tok_cnt_in;
   logic [6:0]               offset_ff, offset_in;
   logic [LINE_POS_W-1:0]    line_pos_ff, line_pos_in;

   // Result buffer: entry zero is the one on the output.
   result_type               buf_ff [3];
   logic [1:0]               buf_cnt_ff;
   result_type               new_res [3];
   logic [1:0]               new_cnt;

   logic                     req_take;
   logic                     rsp_take;
   logic                     delim_hit;
   logic [DELIM_SLOTS-1:0]   delim_match;
   logic [3:0]               delim_used;

   assign rsp_valid = buf_cnt_ff != 2'd0;
   assign rsp_take  = rsp_valid && !rsp_stall;
   // Stall while results other than the one leaving now are still buffered.
   assign req_stall = (buf_cnt_ff > 2'd1) || (buf_cnt_ff == 2'd1 && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign rsp_result_kind  = buf_ff[0].kind;
   assign rsp_token_number = buf_ff[0].token_number;
   assign rsp_char_offset  = buf_ff[0].char_offset;
   assign rsp_char_out     = buf_ff[0].char_out;
   assign rsp_token_total  = buf_ff[0].token_total;
   assign rsp_result_last  = buf_cnt_ff == 2'd1;

   // A delimiter count above eight uses all eight bytes.
   assign delim_used = (delim_count_ff > 4'd8) ? 4'd8 : delim_count_ff;

   // All delimiter slots are compared in parallel.
   always_comb begin
      for (int i = 0; i < DELIM_SLOTS; i++) begin
         delim_match[i] = (delim_bytes_ff[8*i +: 8] == req_char_in) &&
                          (4'(i) < delim_used);
      end
   end
   assign delim_hit = |delim_match;

   // Scan one character and collect the results it causes, in order.
   always_comb begin
      logic                   is_quote;
      logic                   in_range;
      logic                   token_full;
      logic                   close_quote;
      logic [6:0]             offset_inc;
      logic [TOKEN_CNT_W-1:0] tok_prev;
      logic [TOKEN_CNT_W-1:0] tok_open;
      logic                   scan_hit;
      result_type             scan_res;
      result_type             end_res;
      result_type             line_res;
      logic                   open_at_end;

      is_quote    = (req_char_in == CHAR_SQUOTE) || (req_char_in == CHAR_DQUOTE);
      in_range    = line_pos_ff < LINE_POS_W'(LINE_WIDTH);
      token_full  = tok_cnt_ff >= TOKEN_CNT_W'(MAX_TOKENS);
      close_quote = req_char_in == (quote_dq_ff ? CHAR_DQUOTE : CHAR_SQUOTE);
      offset_inc  = (offset_ff == 7'd127) ? offset_ff : offset_ff + 7'd1;
      tok_prev    = tok_cnt_ff - TOKEN_CNT_W'(1);
      scan_hit    = 1'b0;
      scan_res    = '0;

      mode_in     = mode_ff;
      quote_dq_in = quote_dq_ff;
      tok_cnt_in  = tok_cnt_ff;
      offset_in   = offset_ff;
      line_pos_in = line_pos_ff;

      if (in_range) begin
         line_pos_in = line_pos_ff + LINE_POS_W'(1);
         case (mode_ff)
            MODE_BETWEEN: begin
               if (!token_full) begin
                  if (req_char_in == CHAR_LBRACE) begin
                     mode_in = MODE_COMMENT;
                  end else if (is_quote) begin
                     tok_cnt_in  = tok_cnt_ff + TOKEN_CNT_W'(1);
                     mode_in     = MODE_QUOTE;
                     quote_dq_in = req_char_in == CHAR_DQUOTE;
                     offset_in   = 7'd0;
                  end else if (!delim_hit) begin
                     tok_cnt_in = tok_cnt_ff + TOKEN_CNT_W'(1);
                     mode_in    = MODE_WORD;
                     offset_in  = 7'd1;
                     scan_hit   = 1'b1;
                     scan_res   = '{KIND_CHAR, tok_of(tok_cnt_ff), 7'd0, req_char_in, 5'd0};
                  end
               end
            end
            MODE_WORD: begin
               if (delim_hit || is_quote || req_char_in == CHAR_LBRACE) begin
                  // The token ends; a non-delimiter brace, or quote below the token limit, opens its own section.
                  scan_hit  = 1'b1;
                  scan_res  = '{KIND_END, tok_of(tok_prev), offset_ff, 8'd0, 5'd0};
                  mode_in   = MODE_BETWEEN;
                  offset_in = 7'd0;
                  if (!delim_hit) begin
                     if (req_char_in == CHAR_LBRACE) begin
                        mode_in = MODE_COMMENT;
                     end else if (!token_full) begin
                        tok_cnt_in  = tok_cnt_ff + TOKEN_CNT_W'(1);
                        mode_in     = MODE_QUOTE;
                        quote_dq_in = req_char_in == CHAR_DQUOTE;
                     end
                  end
               end else begin
                  scan_hit  = 1'b1;
                  scan_res  = '{KIND_CHAR, tok_of(tok_prev), offset_ff, req_char_in, 5'd0};
                  offset_in = offset_inc;
               end
            end
            MODE_QUOTE: begin
               scan_hit = 1'b1;
               if (close_quote) begin
                  scan_res  = '{KIND_END, tok_of(tok_prev), offset_ff, 8'd0, 5'd0};
                  mode_in   = MODE_BETWEEN;
                  offset_in = 7'd0;
               end else begin
                  scan_res  = '{KIND_CHAR, tok_of(tok_prev), offset_ff, req_char_in, 5'd0};
                  offset_in = offset_inc;
               end
            end
            default: begin
               if (req_char_in == CHAR_RBRACE) begin
                  mode_in = MODE_BETWEEN;
               end
            end
         endcase
      end

      // End of line: close an open token, report the count, clear the state.
      open_at_end = (mode_in == MODE_WORD) || (mode_in == MODE_QUOTE);
      tok_open    = tok_cnt_in - TOKEN_CNT_W'(1);
      end_res     = '{KIND_END, tok_of(tok_open), offset_in, 8'd0, 5'd0};
      line_res    = '{KIND_LINE, 4'd0, 7'd0, 8'd0, total_of(tok_cnt_in)};

      new_res[0] = '0;
      new_res[1] = '0;
      new_res[2] = '0;
      new_cnt    = 2'd0;
      if (scan_hit) begin
         new_res[new_cnt] = scan_res;
         new_cnt          = new_cnt + 2'd1;
      end
      if (req_line_last) begin
         if (open_at_end) begin
            new_res[new_cnt] = end_res;
            new_cnt          = new_cnt + 2'd1;
         end
         new_res[new_cnt] = line_res;
         new_cnt          = new_cnt + 2'd1;
         mode_in     = MODE_BETWEEN;
         quote_dq_in = 1'b0;
         tok_cnt_in  = '0;
         offset_in   = 7'd0;
         line_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff <= DELIM_BYTES_W'(64'd2894124);
         delim_count_ff <= 4'd3;
         mode_ff        <= MODE_BETWEEN;
         quote_dq_ff    <= 1'b0;
         tok_cnt_ff     <= '0;
         offset_ff      <= 7'd0;
         line_pos_ff    <= '0;
         buf_cnt_ff     <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DELIM_BYTES: delim_bytes_ff <= csr_write_data;
               CSR_DELIM_COUNT: delim_count_ff <= csr_write_data[DELIM_COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_take) begin
            mode_ff     <= mode_in;
            quote_dq_ff <= quote_dq_in;
            tok_cnt_ff  <= tok_cnt_in;
            offset_ff   <= offset_in;
            line_pos_ff <= line_pos_in;
            buf_cnt_ff  <= new_cnt;
         end else if (rsp_take) begin
            buf_cnt_ff <= buf_cnt_ff - 2'd1;
         end
      end
      // Buffer payload carries no reset.
      if (req_take) begin
         buf_ff[0] <= new_res[0];
         buf_ff[1] <= new_res[1];
         buf_ff[2] <= new_res[2];
      end else if (rsp_take) begin
         buf_ff[0] <= buf_ff[1];
         buf_ff[1] <= buf_ff[2];
      end
   end

   // A line end always leaves the scan state cleared.
   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_line_last |=> mode_ff == MODE_BETWEEN && tok_cnt_ff == '0 &&
         line_pos_ff == '0 && offset_ff == 7'd0)
      else $error("scan state not cleared after line end");

   // The end-of-line result is always the last one caused by its word.
   a_line_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_LINE |-> rsp_result_last)
      else $error("end-of-line result not marked last");

   // Input is only held back while results are pending.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result buffer");

   // An open token always has a token number behind it.
   a_open_has_token: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_WORD || mode_ff == MODE_QUOTE |-> tok_cnt_ff != '0)
      else $error("open token without a token count");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the card line tokenizer: random lines, per-word result checks.
module tb;
   import ctk_pkg::*;

   // The watchdog fires after this many cycles in which neither channel moves a word.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed for a character that makes no result to clear the block.
   localparam int SETTLE_CYCLES = 8;
   // Length of the one long receiver hold-off, and when it starts.
   localparam int HOLD_CYCLES = 150;
   localparam int HOLD_AFTER_CHARS = 90;
   localparam int MAX_REPORTS = 10;
   // Delimiter set loaded by reset: ',' ')' ',' with three bytes valid.
   localparam logic [DELIM_BYTES_W-1:0] RESET_DELIMS = 64'd2894124;
   localparam logic [DELIM_COUNT_W-1:0] RESET_DELIM_COUNT = 4'd3;

   typedef enum logic [1:0] {
      SCAN_BETWEEN,
      SCAN_WORD,
      SCAN_QUOTE,
      SCAN_COMMENT
   } scan_state_type;

   // One character of a line as the sender offers it.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } card_char_type;

   // One result word with its end-of-step marker.
   typedef struct packed {
      result_type fields;
      logic       last;
   } token_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_char_in = 8'h00;
   logic                     req_line_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_result_kind;
   logic [3:0]               rsp_token_number;
   logic [6:0]               rsp_char_offset;
   logic [7:0]               rsp_char_out;
   logic [4:0]               rsp_token_total;
   logic                     rsp_result_last;
   logic                     csr_write_enable = 1'b0;
   logic                     csr_index = CSR_DELIM_BYTES;
   logic [DELIM_BYTES_W-1:0] csr_write_data = '0;

   card_line_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_line_last    (req_line_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_token_number (rsp_token_number),
      .rsp_char_offset  (rsp_char_offset),
      .rsp_char_out     (rsp_char_out),
      .rsp_token_total  (rsp_token_total),
      .rsp_result_last  (rsp_result_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Period of 12 time units, low first.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Scan state of the tokenizer as this bench predicts it, and its copy of the registers.
   scan_state_type           scan_mode_q;
   logic                     dquote_open;
   int unsigned              tokens_seen;
   int unsigned              token_offset;
   int unsigned              column;
   logic [DELIM_BYTES_W-1:0] delim_bytes_q;
   logic [DELIM_COUNT_W-1:0] delim_count_q;

   // Result words still owed by the block, oldest first, and the words of the current step.
   token_word_type expected_words[$];
   token_word_type step_words[3];
   int             step_count;

   // Characters waiting to be offered, and the line under construction.
   card_char_type card_queue[$];
   logic [7:0]    line_buf[$];
   // Effective delimiters of the current phase, used to shape the stimulus.
   logic [7:0]    delim_set[$];
   int            items_queued = 0;

   int          mismatches = 0;
   int          chars_taken = 0;
   int          results_taken = 0;
   bit          req_fire = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   int          idle_cycles = 0;

   // ---------------------------------------------------------------------------------------
   // Prediction of the tokenizer.
   // ---------------------------------------------------------------------------------------

   function automatic bit is_delimiter(input logic [7:0] c);
      int n;
      n = (delim_count_q > 8) ? 8 : int'(delim_count_q);
      for (int i = 0; i < n; i++)
         if (delim_bytes_q[8*i +: 8] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void emit(input kind_type kind, input int unsigned tok,
                                input int unsigned off, input logic [7:0] ch,
                                input int unsigned total);
      token_word_type w;
      w.fields.kind         = kind;
      w.fields.token_number = tok[3:0];
      w.fields.char_offset  = off[6:0];
      w.fields.char_out     = ch;
      w.fields.token_total  = total[4:0];
      w.last                = 1'b0;
      step_words[step_count] = w;
      step_count++;
   endfunction

   // An end-of-token word carries the token length in the offset field.
   function automatic void close_token();
      emit(KIND_END, tokens_seen - 1, token_offset, 8'h00, 0);
      scan_mode_q  = SCAN_BETWEEN;
      token_offset = 0;
   endfunction

   // A quote past the token limit opens nothing; its token is dropped.
   function automatic void open_quoted(input logic [7:0] c);
      if (tokens_seen < MAX_TOKENS) begin
         tokens_seen++;
         scan_mode_q  = SCAN_QUOTE;
         dquote_open  = (c == CHAR_DQUOTE);
         token_offset = 0;
      end else begin
         scan_mode_q = SCAN_BETWEEN;
      end
   endfunction

   function automatic void add_token_char(input logic [7:0] c);
      emit(KIND_CHAR, tokens_seen - 1, token_offset, c, 0);
      if (token_offset < 127) token_offset++;
   endfunction

   function automatic void clear_scan();
      scan_mode_q  = SCAN_BETWEEN;
      dquote_open  = 1'b0;
      tokens_seen  = 0;
      token_offset = 0;
      column       = 0;
   endfunction

   // Works out the result words of one accepted character and queues them.
   function automatic void predict_char(input logic [7:0] c, input logic last);
      token_word_type w;
      step_count = 0;
      // Characters past the line width are dropped, but the line end still counts.
      if (column < LINE_WIDTH) begin
         column++;
         case (scan_mode_q)
            SCAN_BETWEEN: begin
               // Once the token limit is hit, nothing more opens here: no token, quote or comment.
               // Otherwise a brace wins over a quote, and a quote over a delimiter.
               if (tokens_seen < MAX_TOKENS) begin
                  if (c == CHAR_LBRACE) begin
                     scan_mode_q = SCAN_COMMENT;
                  end else if (c == CHAR_SQUOTE || c == CHAR_DQUOTE) begin
                     open_quoted(c);
                  end else if (!is_delimiter(c)) begin
                     tokens_seen++;
                     scan_mode_q  = SCAN_WORD;
                     token_offset = 0;
                     add_token_char(c);
                  end
               end
            end
            SCAN_WORD: begin
               // Inside a bare token the delimiter test comes first.
               if (is_delimiter(c)) begin
                  close_token();
               end else if (c == CHAR_LBRACE) begin
                  close_token();
                  scan_mode_q = SCAN_COMMENT;
               end else if (c == CHAR_SQUOTE || c == CHAR_DQUOTE) begin
                  close_token();
                  open_quoted(c);
               end else begin
                  add_token_char(c);
               end
            end
            SCAN_QUOTE: begin
               if (c == (dquote_open ? CHAR_DQUOTE : CHAR_SQUOTE)) close_token();
               else add_token_char(c);
            end
            default: begin
               if (c == CHAR_RBRACE) scan_mode_q = SCAN_BETWEEN;
            end
         endcase
      end
      // The line end closes an open token, reports the count and clears everything.
      // An open comment just goes away.
      if (last) begin
         if (scan_mode_q == SCAN_WORD || scan_mode_q == SCAN_QUOTE) close_token();
         emit(KIND_LINE, 0, 0, 8'h00, tokens_seen);
         clear_scan();
      end
      for (int i = 0; i < step_count; i++) begin
         w      = step_words[i];
         w.last = (i == step_count - 1);
         expected_words.push_back(w);
      end
   endfunction

   function automatic string describe(input token_word_type w);
      return $sformatf("kind %0d token %0d offset %0d char %h total %0d last %0b",
                       w.fields.kind, w.fields.token_number, w.fields.char_offset,
                       w.fields.char_out, w.fields.token_total, w.last);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus shaping.
   // ---------------------------------------------------------------------------------------

   function automatic void load_delim_set(input logic [DELIM_BYTES_W-1:0] bytes,
                                          input logic [DELIM_COUNT_W-1:0] count);
      int n;
      n = (count > 8) ? 8 : int'(count);
      delim_set.delete();
      for (int i = 0; i < n; i++) delim_set.push_back(bytes[8*i +: 8]);
   endfunction

   function automatic bit is_special(input logic [7:0] c);
      if (c == CHAR_LBRACE || c == CHAR_SQUOTE || c == CHAR_DQUOTE) return 1'b1;
      foreach (delim_set[i])
         if (delim_set[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   // A character that stays inside a bare token: mostly letters, sometimes any byte.
   function automatic logic [7:0] word_char();
      logic [7:0] c;
      repeat (8) begin
         if ($urandom_range(1) == 0) c = 8'($urandom_range(8'h61, 8'h7A));
         else c = 8'($urandom_range(255));
         if (!is_special(c)) return c;
      end
      for (int i = 8'h41; i < 256; i++)
         if (!is_special(8'(i))) return 8'(i);
      return 8'h41;
   endfunction

   function automatic logic [7:0] pick_delim();
      return delim_set[$urandom_range(delim_set.size() - 1)];
   endfunction

   // Moves the line under construction to the send queue, marking its last character.
   function automatic void push_line();
      card_char_type item;
      if (line_buf.size() == 0) line_buf.push_back(word_char());
      foreach (line_buf[i]) begin
         item.ch   = line_buf[i];
         item.last = (i == line_buf.size() - 1);
         card_queue.push_back(item);
      end
      items_queued += line_buf.size();
      line_buf.delete();
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      push_line();
   endfunction

   // One piece of a well-formed line: a bare token, a quoted token or a comment.
   function automatic void add_piece(input int max_word);
      int         kind;
      logic [7:0] q;
      logic [7:0] c;
      if (delim_set.size() != 0 && $urandom_range(2) == 0)
         repeat ($urandom_range(1, 2)) line_buf.push_back(pick_delim());
      kind = $urandom_range(9);
      if (kind < 6) begin
         repeat ($urandom_range(1, max_word)) line_buf.push_back(word_char());
      end else if (kind < 9) begin
         q = ($urandom_range(1) == 0) ? CHAR_SQUOTE : CHAR_DQUOTE;
         line_buf.push_back(q);
         repeat ($urandom_range(0, 3)) begin
            c = 8'($urandom_range(255));
            if (c == q) c = c ^ 8'h01;
            line_buf.push_back(c);
         end
         line_buf.push_back(q);
      end else begin
         line_buf.push_back(CHAR_LBRACE);
         repeat ($urandom_range(0, 3)) begin
            c = 8'($urandom_range(255));
            if (c == CHAR_RBRACE) c = 8'h20;
            line_buf.push_back(c);
         end
         line_buf.push_back(CHAR_RBRACE);
      end
      if (delim_set.size() != 0 && $urandom_range(3) != 0) line_buf.push_back(pick_delim());
   endfunction

   // A line of several pieces, sometimes broken off inside a quote or a comment,
   // or trailing off in delimiters.
   function automatic void gen_line(input int pieces, input int min_len);
      int i;
      i = 0;
      while (i < pieces || line_buf.size() < min_len) begin
         add_piece(6);
         i++;
      end
      case ($urandom_range(5))
         0: begin
            line_buf.push_back(($urandom_range(1) == 0) ? CHAR_SQUOTE : CHAR_DQUOTE);
            repeat ($urandom_range(0, 2)) line_buf.push_back(word_char());
         end
         1: begin
            line_buf.push_back(CHAR_LBRACE);
            line_buf.push_back(word_char());
         end
         2: begin
            if (delim_set.size() != 0) line_buf.push_back(pick_delim());
         end
         default: ;
      endcase
      push_line();
   endfunction

   // More one-character tokens than the limit allows, then a quote and a comment.
   function automatic void many_tokens();
      repeat (MAX_TOKENS + 2) begin
         line_buf.push_back(word_char());
         if (delim_set.size() != 0) line_buf.push_back(pick_delim());
         else line_buf.push_back(CHAR_SQUOTE);
      end
      line_buf.push_back(CHAR_DQUOTE);
      line_buf.push_back(CHAR_LBRACE);
      line_buf.push_back(word_char());
      push_line();
   endfunction

   // Random lines until the phase has queued about the given number of characters.
   // Some lines are plain noise over the whole byte range.
   function automatic void random_lines(input int budget);
      int start;
      start = items_queued;
      while (items_queued - start < budget) begin
         if ($urandom_range(99) < 18) begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
            push_line();
         end else begin
            gen_line($urandom_range(1, 5), 0);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sequencing of the run.
   // ---------------------------------------------------------------------------------------

   // Writes both delimiter registers on consecutive cycles; the block is idle here.
   task automatic set_delimiters(input logic [DELIM_BYTES_W-1:0] bytes,
                                 input logic [DELIM_COUNT_W-1:0] count);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DELIM_BYTES;
      csr_write_data   <= bytes;
      @(negedge clock);
      csr_index        <= CSR_DELIM_COUNT;
      csr_write_data   <= {{(DELIM_BYTES_W - DELIM_COUNT_W){1'b0}}, count};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      load_delim_set(bytes, count);
   endtask

   // Returns once every queued character is taken and every result word has come,
   // and then lets characters that make no result at all clear the block.
   task automatic wait_idle();
      do @(posedge clock);
      while (card_queue.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset delimiters. The directed lines cover an empty quote, a quote left open at
      // the line end, a brace and a quote ending bare tokens, the extreme byte values,
      // and a line of delimiters alone, which must not make an empty token.
      load_delim_set(RESET_DELIMS, RESET_DELIM_COUNT);
      push_text("ab,'',\"x'y");
      push_text("c{z}d\"");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h29);
      line_buf.push_back(8'h00);
      push_line();
      push_text("),");
      random_lines(25);
      wait_idle();

      // Semicolon, tab, space and comma; a line that overruns the token limit.
      set_delimiters(64'h0000_0000_2C20_093B, 4'd4);
      many_tokens();
      random_lines(20);
      wait_idle();

      // No delimiters at all, and one line longer than the line width.
      set_delimiters({$urandom(), $urandom()}, 4'd0);
      gen_line(3, LINE_WIDTH + 4);
      random_lines(15);
      wait_idle();

      // A count above eight, with the brace, the quote and the closing brace as
      // delimiters so that the precedence rules come into play.
      set_delimiters(64'h2E7D_3AFF_0020_277B, 4'd15);
      many_tokens();
      random_lines(20);
      wait_idle();

      // All-ones register: only 0xFF separates tokens.
      set_delimiters('1, 4'd8);
      random_lines(30);
      wait_idle();

      set_delimiters({$urandom(), $urandom()}, 4'($urandom_range(15)));
      random_lines(25);
      wait_idle();

      // All-zero register with one byte valid: the NUL character separates tokens.
      set_delimiters('0, 4'd1);
      many_tokens();
      random_lines(20);
      wait_idle();

      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Sender: offers the next character at the falling edge, holds it until taken, and
   // now and then leaves a gap. Gaps stop for a stretch in the middle of the run.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      card_char_type next_char;
      bit            gap;
      gap = !(chars_taken >= 150 && chars_taken < 260) && ($urandom_range(99) < 8);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // Still stalled: the word stays as it is.
      end else if (card_queue.size() != 0 && !gap) begin
         next_char = card_queue.pop_front();
         req_valid     <= 1'b1;
         req_char_in   <= next_char.ch;
         req_line_last <= next_char.last;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: random stalls, a quiet stretch, and one long hold-off while the sender keeps
   // offering characters, so the result buffer fills and the block stalls its input.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && chars_taken >= HOLD_AFTER_CHARS) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !(results_taken >= 300 && results_taken < 420) &&
                      ($urandom_range(99) < 8);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: at each rising edge it tracks register writes, predicts the results of an
   // accepted character and checks an accepted result word against the oldest prediction.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      token_word_type seen;
      token_word_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (reset) begin
         clear_scan();
         delim_bytes_q = RESET_DELIMS;
         delim_count_q = RESET_DELIM_COUNT;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_DELIM_BYTES) delim_bytes_q = csr_write_data;
            else delim_count_q = csr_write_data[DELIM_COUNT_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            seen.fields.kind         = kind_type'(rsp_result_kind);
            seen.fields.token_number = rsp_token_number;
            seen.fields.char_offset  = rsp_char_offset;
            seen.fields.char_out     = rsp_char_out;
            seen.fields.token_total  = rsp_token_total;
            seen.last                = rsp_result_last;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result word with none expected: %s", $time, describe(seen));
            end else begin
               want = expected_words.pop_front();
               if (want.fields.kind !== seen.fields.kind ||
                   want.fields.token_number !== seen.fields.token_number ||
                   want.fields.char_offset !== seen.fields.char_offset ||
                   want.fields.char_out !== seen.fields.char_out ||
                   want.fields.token_total !== seen.fields.token_total ||
                   want.last !== seen.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: result word %0d differs", $time, results_taken);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(seen));
                  end
               end
            end
         end
         if (req_fire) begin
            chars_taken++;
            predict_char(req_char_in, req_line_last);
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

>>> sim.f
rtl/ctk_pkg.sv
rtl/card_line_tokenizer.sv
tb/tb.sv
